/* src/two_class_state_scheduler_macros.svh */
// ----------------------------------------------------------------------------
// Two-class state scheduler assertion macros
// Shared property forms for the scheduler checkers.
// ----------------------------------------------------------------------------
`ifndef TWO_CLASS_STATE_SCHEDULER_MACROS_SVH
`define TWO_CLASS_STATE_SCHEDULER_MACROS_SVH

// same-cycle implication
`define TCSS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// next-cycle implication
`define TCSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

/* src/tcss_pkg.sv */
// ----------------------------------------------------------------------------
// Two-class state scheduler package
// Codes, state encoding, stack control and shared constants.
// ----------------------------------------------------------------------------
`default_nettype none

package tcss_pkg;

  localparam int DEF_STACK_DEPTH = 16;
  localparam int DEF_ID_WIDTH    = 16;
  localparam int DEF_NUM_TRACKED = 4;

  localparam int PC_W      = 64;
  localparam int ADDR_W    = 47;
  localparam int COUNT_W   = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic [PC_W-1:0] PC_LIMIT = 64'h0000_7f00_0000_0000;

  localparam logic [CFG_IDX_W-1:0] CFG_TRACKED_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACKED_ADDR_A = 3'd1;

  localparam logic SIDE_HIGH = 1'b0;
  localparam logic SIDE_LOW  = 1'b1;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_FORK   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_SELECT = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_HIGH  = 3'd1,
    ACT_LOW   = 3'd2,
    ACT_TERM  = 3'd3,
    ACT_SEL   = 3'd4,
    ACT_EMPTY = 3'd5,
    ACT_MISS  = 3'd6,
    ACT_FULL  = 3'd7
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_MATCH,
    ST_PUSH,
    ST_SEL_TAKE,
    ST_SRCH_READ,
    ST_SRCH_CHECK,
    ST_SHIFT_READ,
    ST_SHIFT_WRITE,
    ST_RESPOND
  } state_t;

  typedef struct packed {
    logic push;
    logic write;
    logic dec;
  } stack_ctl_t;

endpackage

`default_nettype wire

/* src/tcss_stack.sv */
// ----------------------------------------------------------------------------
// Scheduler ID stack
// Entry memory with one write and one registered read port, plus fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module tcss_stack
  import tcss_pkg::*;
#(
  parameter int DEPTH = DEF_STACK_DEPTH,
  parameter int WIDTH = DEF_ID_WIDTH,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int FW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire stack_ctl_t       ctl,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata,
  output logic      [FW-1:0]    fill
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_addr;

  assign wr_addr = ctl.push ? fill[AW-1:0] : waddr;

  always_ff @(posedge clk) begin
    if (ctl.push || ctl.write) begin
      mem[wr_addr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (ctl.push) begin
      fill <= fill + 1'b1;
    end else if (ctl.dec) begin
      fill <= fill - 1'b1;
    end
  end

endmodule

`default_nettype wire

/* src/two_class_state_scheduler.sv */
// ----------------------------------------------------------------------------
// Two-class state scheduler
// Two LIFO stacks of state IDs with add, fork, remove and select events.
// ----------------------------------------------------------------------------
// Requests enter on req_valid/req_ready with operation, state_id, parent_id,
// target_pc and module_known; one result per request leaves on
// res_valid/res_ready with action, selected_id and low_empty.
// Tracked addresses and their count are written on cfg_write/cfg_index/
// cfg_data, by the user only while no request is in flight; not enforced.
// One request is processed at a time by a single sequencer sharing one
// stack read port and one compare. A remove searches each stack memory,
// the high stack first and then the low one, and shifts the entries above
// a match down by one.
// req_ready is high only while the sequencer is idle, so the next request is
// taken in the cycle after the previous result is loaded. The result register
// holds a finished result while the receiver stalls; the next request may be
// taken meanwhile and waits at its end until the register frees up.
// Reset empties both stacks, clears the tracked registers and re-arms the
// initial add; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module two_class_state_scheduler
  import tcss_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int ID_WIDTH    = DEF_ID_WIDTH,
  parameter int NUM_TRACKED = DEF_NUM_TRACKED
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ADDR_W-1:0]    cfg_data,
  input  wire logic                 req_valid,
  output logic                      req_ready,
  input  wire logic [1:0]           operation,
  input  wire logic [ID_WIDTH-1:0]  state_id,
  input  wire logic [ID_WIDTH-1:0]  parent_id,
  input  wire logic [PC_W-1:0]      target_pc,
  input  wire logic                 module_known,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output action_t                   action,
  output logic      [ID_WIDTH-1:0]  selected_id,
  output logic                      low_empty
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int FW = $clog2(STACK_DEPTH + 1);
  localparam int KW = (NUM_TRACKED > 1) ? $clog2(NUM_TRACKED) : 1;

  logic [COUNT_W-1:0] tracked_count;
  logic [ADDR_W-1:0]  tracked [NUM_TRACKED];

  state_t state, state_next;

  op_t               op_r;
  logic [ID_WIDTH-1:0] sid_r;
  logic [ID_WIDTH-1:0] pid_r;
  logic [PC_W-1:0]   pc_r;
  logic              known_r;
  action_t           act;
  logic [ID_WIDTH-1:0] sel_r;
  logic              hit;
  logic              side;
  logic [FW-1:0]     idx;
  logic [KW-1:0]     k;
  logic              first_add_done;

  stack_ctl_t        ctl_high, ctl_low, ctl_cur;
  logic [AW-1:0]     rd_addr;
  logic [ID_WIDTH-1:0] wr_data;
  logic [ID_WIDTH-1:0] high_rdata, low_rdata, cur_rdata;
  logic [FW-1:0]     high_fill, low_fill, cur_fill;
  logic [FW-1:0]     idx_inc, top_full;
  logic              cur_full, term, match_hit, last_k, both_empty;
  logic              scan_end, shift_end;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tracked_count <= '0;
    end else if (cfg_write && cfg_index == CFG_TRACKED_COUNT) begin
      tracked_count <= cfg_data[COUNT_W-1:0];
    end
  end

  for (genvar g = 0; g < NUM_TRACKED; g++) begin : g_tracked
    always_ff @(posedge clk) begin
      if (rst) begin
        tracked[g] <= '0;
      end else if (cfg_write && cfg_index == CFG_IDX_W'(CFG_TRACKED_ADDR_A + g)) begin
        tracked[g] <= cfg_data;
      end
    end
  end

  tcss_stack #(.DEPTH(STACK_DEPTH), .WIDTH(ID_WIDTH)) u_high (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl_high),
    .waddr (idx[AW-1:0]),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (high_rdata),
    .fill  (high_fill)
  );

  tcss_stack #(.DEPTH(STACK_DEPTH), .WIDTH(ID_WIDTH)) u_low (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl_low),
    .waddr (idx[AW-1:0]),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (low_rdata),
    .fill  (low_fill)
  );

  assign cur_fill   = (side == SIDE_LOW) ? low_fill : high_fill;
  assign cur_rdata  = (side == SIDE_LOW) ? low_rdata : high_rdata;
  assign cur_full   = (cur_fill == FW'(STACK_DEPTH));
  assign idx_inc    = idx + 1'b1;
  assign scan_end   = (idx >= cur_fill);
  assign shift_end  = (idx_inc >= cur_fill);
  assign both_empty = (high_fill == '0) && (low_fill == '0);
  assign top_full   = ((high_fill != '0) ? high_fill : low_fill) - 1'b1;
  assign term       = (sid_r == pid_r) || (pc_r >= PC_LIMIT);
  assign match_hit  = (COUNT_W'(k) < tracked_count)
                      && (pc_r[PC_W-1:ADDR_W] == '0)
                      && (pc_r[ADDR_W-1:0] == tracked[k]);
  assign last_k     = (k == KW'(NUM_TRACKED - 1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        unique case (op_r)
          OP_ADD:    state_next = first_add_done ? ST_RESPOND : ST_PUSH;
          OP_FORK:   state_next = (!known_r || term) ? ST_RESPOND : ST_MATCH;
          OP_REMOVE: state_next = ST_SRCH_READ;
          OP_SELECT: state_next = both_empty ? ST_RESPOND : ST_SEL_TAKE;
          default:   state_next = ST_RESPOND;
        endcase
      end
      ST_MATCH: begin
        if (match_hit || last_k) state_next = ST_PUSH;
      end
      ST_PUSH:     state_next = ST_RESPOND;
      ST_SEL_TAKE: state_next = ST_RESPOND;
      ST_SRCH_READ: begin
        if (!scan_end) state_next = ST_SRCH_CHECK;
        else if (side == SIDE_LOW) state_next = ST_RESPOND;
      end
      ST_SRCH_CHECK: begin
        state_next = (cur_rdata == sid_r) ? ST_SHIFT_READ : ST_SRCH_READ;
      end
      ST_SHIFT_READ: begin
        if (!shift_end) state_next = ST_SHIFT_WRITE;
        else if (side == SIDE_LOW) state_next = ST_RESPOND;
        else state_next = ST_SRCH_READ;
      end
      ST_SHIFT_WRITE: state_next = ST_SHIFT_READ;
      ST_RESPOND: begin
        if (!res_valid || res_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    req_ready = (state == ST_IDLE);
    ctl_cur   = '0;
    rd_addr   = idx[AW-1:0];
    wr_data   = sid_r;
    unique case (state)
      ST_DISPATCH:    rd_addr = top_full[AW-1:0];
      ST_PUSH:        ctl_cur.push = !cur_full;
      ST_SHIFT_READ: begin
        rd_addr     = idx_inc[AW-1:0];
        ctl_cur.dec = shift_end;
      end
      ST_SHIFT_WRITE: begin
        ctl_cur.write = 1'b1;
        wr_data       = cur_rdata;
      end
      default: ;
    endcase
    ctl_high = (side == SIDE_HIGH) ? ctl_cur : '0;
    ctl_low  = (side == SIDE_LOW)  ? ctl_cur : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          op_r    <= op_t'(operation);
          sid_r   <= state_id;
          pid_r   <= parent_id;
          pc_r    <= target_pc;
          known_r <= module_known;
          act     <= ACT_NONE;
          sel_r   <= '0;
          hit     <= 1'b0;
          side    <= SIDE_HIGH;
          idx     <= '0;
          k       <= '0;
        end
      end
      ST_DISPATCH: begin
        unique case (op_r)
          OP_ADD: begin
            if (!first_add_done) side <= SIDE_LOW;
          end
          OP_FORK: begin
            if (known_r && term) act <= ACT_TERM;
          end
          OP_SELECT: begin
            side <= (high_fill != '0) ? SIDE_HIGH : SIDE_LOW;
            if (both_empty) act <= ACT_EMPTY;
          end
          default: ;
        endcase
      end
      ST_MATCH: begin
        if (match_hit) side <= SIDE_HIGH;
        else if (last_k) side <= SIDE_LOW;
        else k <= k + 1'b1;
      end
      ST_PUSH: begin
        if (cur_full) act <= ACT_FULL;
        else act <= (side == SIDE_HIGH) ? ACT_HIGH : ACT_LOW;
      end
      ST_SEL_TAKE: begin
        sel_r <= cur_rdata;
        act   <= ACT_SEL;
      end
      ST_SRCH_READ: begin
        if (scan_end) begin
          if (side == SIDE_HIGH) begin
            side <= SIDE_LOW;
            idx  <= '0;
          end else begin
            act <= hit ? ACT_NONE : ACT_MISS;
          end
        end
      end
      ST_SRCH_CHECK: begin
        if (cur_rdata == sid_r) hit <= 1'b1;
        else idx <= idx_inc;
      end
      ST_SHIFT_READ: begin
        if (shift_end && side == SIDE_HIGH) begin
          side <= SIDE_LOW;
          idx  <= '0;
        end
      end
      ST_SHIFT_WRITE: idx <= idx_inc;
      default: ;
    endcase
  end

  // result register and first-add flag
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid      <= 1'b0;
      first_add_done <= 1'b0;
    end else begin
      if (state == ST_DISPATCH && op_r == OP_ADD) first_add_done <= 1'b1;
      if (state == ST_RESPOND && (!res_valid || res_ready)) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESPOND && (!res_valid || res_ready)) begin
      action      <= act;
      selected_id <= sel_r;
      low_empty   <= (low_fill == '0);
    end
  end

endmodule

`default_nettype wire

/* src/tcss_checker.sv */
// ----------------------------------------------------------------------------
// Two-class state scheduler checker
// Port-level properties of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "two_class_state_scheduler_macros.svh"

module tcss_checker
  import tcss_pkg::*;
#(
  parameter int ID_WIDTH = DEF_ID_WIDTH
) (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                req_valid,
  input wire logic                req_ready,
  input wire logic                res_valid,
  input wire logic                res_ready,
  input wire action_t             action,
  input wire logic [ID_WIDTH-1:0] selected_id,
  input wire logic                low_empty
);

  `TCSS_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(action) && $stable(selected_id))
  `TCSS_ASSERT_NEXT(a_busy_after_req, clk, rst, req_valid && req_ready, !req_ready)
  `TCSS_ASSERT_SAME(a_sel_id_zero, clk, rst, res_valid && action != ACT_SEL, selected_id == '0)
  `TCSS_ASSERT_SAME(a_empty_low, clk, rst, res_valid && action == ACT_EMPTY, low_empty)

endmodule

bind two_class_state_scheduler tcss_checker #(.ID_WIDTH(ID_WIDTH)) u_tcss_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req_valid),
  .req_ready   (req_ready),
  .res_valid   (res_valid),
  .res_ready   (res_ready),
  .action      (action),
  .selected_id (selected_id),
  .low_empty   (low_empty)
);

`default_nettype wire

/* test/two_class_state_scheduler_tb.sv */
// ----------------------------------------------------------------------------
// Two-class state scheduler testbench
// Drives add, fork, remove and select requests with random gaps on both
// handshakes, predicts every result from its own copy of the two stacks and
// the tracked-address registers, and checks the results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module two_class_state_scheduler_tb;
  import tcss_pkg::*;

  localparam int ID_W        = DEF_ID_WIDTH;
  localparam int DEPTH       = DEF_STACK_DEPTH;
  localparam int NUM_TRK     = DEF_NUM_TRACKED;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 6;
  localparam int PHASE_REQS  = 130;

  typedef struct {
    action_t         act;
    logic [ID_W-1:0] sel;
    logic            low_empty;
  } sched_result_t;

  class sched_scoreboard;
    logic [ID_W-1:0]    high_ids[$];
    logic [ID_W-1:0]    low_ids[$];
    bit                 first_add_seen;
    logic [COUNT_W-1:0] tracked_num;
    logic [ADDR_W-1:0]  tracked_addr[NUM_TRK];
    sched_result_t      expected_q[$];
    int                 errors;
    int                 accepted;
    int                 checked;
    int                 action_hits[8];

    function new();
      first_add_seen = 1'b0;
      tracked_num = '0;
      foreach (tracked_addr[i]) tracked_addr[i] = '0;
      errors = 0;
      accepted = 0;
      checked = 0;
      foreach (action_hits[i]) action_hits[i] = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
      if (idx == CFG_TRACKED_COUNT) tracked_num = data[COUNT_W-1:0];
      else if (int'(idx) < int'(CFG_TRACKED_ADDR_A) + NUM_TRK)
        tracked_addr[int'(idx) - int'(CFG_TRACKED_ADDR_A)] = data;
    endfunction

    function bit pc_is_tracked(logic [PC_W-1:0] pc);
      int n;
      n = (tracked_num > NUM_TRK) ? NUM_TRK : int'(tracked_num);
      for (int i = 0; i < n; i++)
        if (pc == PC_W'(tracked_addr[i])) return 1'b1;
      return 1'b0;
    endfunction

    function action_t push_id(bit to_high, logic [ID_W-1:0] id);
      if (to_high) begin
        if (high_ids.size() >= DEPTH) return ACT_FULL;
        high_ids = {high_ids, id};
        return ACT_HIGH;
      end
      if (low_ids.size() >= DEPTH) return ACT_FULL;
      low_ids = {low_ids, id};
      return ACT_LOW;
    endfunction

    function int find_first(logic [ID_W-1:0] ids[$], logic [ID_W-1:0] id);
      for (int i = 0; i < ids.size(); i++)
        if (ids[i] == id) return i;
      return -1;
    endfunction

    function void note_request(op_t op, logic [ID_W-1:0] sid, logic [ID_W-1:0] pid,
                               logic [PC_W-1:0] pc, logic known);
      sched_result_t r;
      int hi;
      int lo;
      r.act = ACT_NONE;
      r.sel = '0;
      case (op)
        OP_ADD: begin
          if (!first_add_seen) begin
            r.act = push_id(1'b0, sid);
            first_add_seen = 1'b1;
          end
        end
        OP_FORK: begin
          if (known) begin
            if (sid == pid || pc >= PC_LIMIT) r.act = ACT_TERM;
            else r.act = push_id(pc_is_tracked(pc), sid);
          end
        end
        OP_REMOVE: begin
          hi = find_first(high_ids, sid);
          lo = find_first(low_ids, sid);
          if (hi >= 0) high_ids.delete(hi);
          if (lo >= 0) low_ids.delete(lo);
          if (hi < 0 && lo < 0) r.act = ACT_MISS;
        end
        default: begin
          if (high_ids.size() > 0) begin
            r.act = ACT_SEL;
            r.sel = high_ids[$];
          end else if (low_ids.size() > 0) begin
            r.act = ACT_SEL;
            r.sel = low_ids[$];
          end else begin
            r.act = ACT_EMPTY;
          end
        end
      endcase
      r.low_empty = (low_ids.size() == 0);
      expected_q = {expected_q, r};
      accepted++;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(action_t act, logic [ID_W-1:0] sel, logic le);
      sched_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with no request pending (action %0d)", act));
        return;
      end
      want = expected_q.pop_front();
      checked++;
      action_hits[want.act]++;
      if (act !== want.act)
        report($sformatf("result %0d action %0d, want %0d", checked, act, want.act));
      if (sel !== want.sel)
        report($sformatf("result %0d selected_id %h, want %h", checked, sel, want.sel));
      if (le !== want.low_empty)
        report($sformatf("result %0d low_empty %b, want %b", checked, le, want.low_empty));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0]    cfg_data = '0;
  logic                 req_valid = 1'b0;
  logic                 req_ready;
  logic [1:0]           operation = '0;
  logic [ID_W-1:0]      state_id = '0;
  logic [ID_W-1:0]      parent_id = '0;
  logic [PC_W-1:0]      target_pc = '0;
  logic                 module_known = 1'b0;
  logic                 res_valid;
  logic                 res_ready = 1'b0;
  action_t              action;
  logic [ID_W-1:0]      selected_id;
  logic                 low_empty;

  sched_scoreboard sb = new();
  bit   tx_idle = 1'b1;
  bit   rx_idle = 1'b1;
  bit   hold_results = 1'b0;
  int   op_weight[4];
  int   config_count = 0;
  int   cycle_count = 0;

  two_class_state_scheduler dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .operation   (operation),
    .state_id    (state_id),
    .parent_id   (parent_id),
    .target_pc   (target_pc),
    .module_known(module_known),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .action      (action),
    .selected_id (selected_id),
    .low_empty   (low_empty)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 60);
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return ID_W'($urandom_range(0, 23));
    if (r < 90) return ID_W'($urandom);
    return {ID_W{1'b1}} - ID_W'($urandom_range(0, 3));
  endfunction

  // mostly IDs that are on a stack, so removes tend to hit
  function automatic logic [ID_W-1:0] pick_stacked_id();
    int n;
    int k;
    n = sb.high_ids.size() + sb.low_ids.size();
    if (n == 0 || $urandom_range(0, 9) < 3) return pick_id();
    k = $urandom_range(0, n - 1);
    if (k < sb.high_ids.size()) return sb.high_ids[k];
    return sb.low_ids[k - sb.high_ids.size()];
  endfunction

  function automatic logic [PC_W-1:0] pick_pc();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return PC_W'(sb.tracked_addr[$urandom_range(0, NUM_TRK - 1)]);
    if (r < 85) return PC_W'(ADDR_W'({$urandom, $urandom}));
    return {$urandom, $urandom};
  endfunction

  function automatic op_t pick_op();
    int r;
    r = $urandom_range(0, op_weight[0] + op_weight[1] + op_weight[2] + op_weight[3] - 1);
    if (r < op_weight[0]) return OP_ADD;
    r -= op_weight[0];
    if (r < op_weight[1]) return OP_FORK;
    r -= op_weight[1];
    if (r < op_weight[2]) return OP_REMOVE;
    return OP_SELECT;
  endfunction

  task automatic send_request(op_t op, logic [ID_W-1:0] sid, logic [ID_W-1:0] pid,
                              logic [PC_W-1:0] pc, logic known);
    int gap;
    req_valid    <= 1'b1;
    operation    <= op;
    state_id     <= sid;
    parent_id    <= pid;
    target_pc    <= pc;
    module_known <= known;
    do @(posedge clk); while (!req_ready);
    sb.note_request(op, sid, pid, pc, known);
    gap = (tx_idle && $urandom_range(0, 2) == 0) ? stall_len() : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // returns 1 when the request does something in the block
  task automatic send_random(output bit useful);
    op_t             op;
    logic [ID_W-1:0] sid;
    logic [ID_W-1:0] pid;
    logic            known;
    op = pick_op();
    sid = (op == OP_REMOVE) ? pick_stacked_id() : pick_id();
    pid = ($urandom_range(0, 19) == 0) ? sid : pick_id();
    known = ($urandom_range(0, 9) != 0);
    useful = !(op == OP_ADD && sb.first_add_seen) && !(op == OP_FORK && !known);
    send_request(op, sid, pid, pick_pc(), known);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic configure(logic [COUNT_W-1:0] num, logic [ADDR_W-1:0] addrs[NUM_TRK]);
    cfg_write <= 1'b1;
    cfg_index <= CFG_TRACKED_COUNT;
    cfg_data  <= ADDR_W'(num);
    sb.write_reg(CFG_TRACKED_COUNT, ADDR_W'(num));
    @(posedge clk);
    for (int i = 0; i < NUM_TRK; i++) begin
      cfg_index <= CFG_IDX_W'(int'(CFG_TRACKED_ADDR_A) + i);
      cfg_data  <= addrs[i];
      sb.write_reg(CFG_IDX_W'(int'(CFG_TRACKED_ADDR_A) + i), addrs[i]);
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    config_count++;
  endtask

  initial begin : result_sink
    int pause_left;
    pause_left = 0;
    forever begin
      @(posedge clk);
      if (res_valid && res_ready) sb.check_result(action, selected_id, low_empty);
      if (hold_results) begin
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
        res_ready <= 1'b1;
      end else if (pause_left > 0) begin
        pause_left--;
        res_ready <= 1'b0;
      end else if (rx_idle && $urandom_range(0, 3) == 0) begin
        pause_left = stall_len() - 1;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    logic [ADDR_W-1:0] addrs[NUM_TRK];
    logic [ADDR_W-1:0] dup_addr;
    logic [ID_W-1:0]   sid;
    int                count_tab[PHASES];
    int                mix[PHASES][4];
    bit                useful;
    int                done;
    count_tab = '{4, 1, 6, 0, 3, 2};
    mix = '{'{1, 6, 2, 3}, '{1, 2, 6, 3}, '{1, 4, 4, 3},
            '{1, 6, 1, 1}, '{0, 3, 5, 3}, '{1, 4, 3, 4}};
    dup_addr = 47'h1234_5678_9abc;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: nothing tracked
    send_request(OP_SELECT, '0, '0, '0, 1'b0);
    send_request(OP_REMOVE, 16'h1234, '0, '0, 1'b0);
    send_request(OP_FORK, 16'h0005, 16'h0006, '0, 1'b0);
    send_request(OP_FORK, 16'hffff, 16'hffff, '0, 1'b1);
    send_request(OP_FORK, 16'h0001, 16'h0002, PC_LIMIT, 1'b1);
    send_request(OP_FORK, 16'h0001, 16'h0002, {PC_W{1'b1}}, 1'b1);
    send_request(OP_FORK, 16'h0000, 16'hffff, PC_LIMIT - 64'd1, 1'b1);
    send_request(OP_FORK, 16'hffff, 16'h0000, '0, 1'b1);
    send_request(OP_FORK, 16'h0007, 16'h0000, 64'h1000, 1'b1);
    send_request(OP_REMOVE, 16'hffff, '0, '0, 1'b0);
    send_request(OP_SELECT, '0, '0, '0, 1'b0);
    send_request(OP_REMOVE, 16'h0007, '0, '0, 1'b0);
    send_request(OP_SELECT, '0, '0, '0, 1'b0);
    drain();

    // oversized count, duplicate tracked addresses, one above the PC limit
    addrs = '{'0, {ADDR_W{1'b1}}, dup_addr, dup_addr};
    configure(3'd7, addrs);
    send_request(OP_FORK, 16'h0010, 16'h0001, '0, 1'b1);
    send_request(OP_FORK, 16'h0011, 16'h0001, PC_W'(dup_addr), 1'b1);
    send_request(OP_FORK, 16'h0012, 16'h0001, PC_W'({ADDR_W{1'b1}}), 1'b1);
    send_request(OP_SELECT, '0, '0, '0, 1'b0);
    send_request(OP_FORK, 16'h0010, 16'h0001, 64'h2000, 1'b1);
    send_request(OP_REMOVE, 16'h0010, '0, '0, 1'b0);
    send_request(OP_SELECT, '0, '0, '0, 1'b0);
    send_request(OP_REMOVE, 16'h0011, '0, '0, 1'b0);
    send_request(OP_SELECT, '0, '0, '0, 1'b0);

    // fill the low stack, then make the first add land on a full stack
    while (sb.low_ids.size() < DEPTH) begin
      sid = pick_id();
      send_request(OP_FORK, sid, ~sid, PC_W'(ADDR_W'($urandom)) | 64'h1, 1'b1);
    end
    send_request(OP_FORK, 16'h0020, 16'h0021, 64'h3000, 1'b1);
    send_request(OP_ADD, 16'h0030, '0, '0, 1'b0);
    send_request(OP_ADD, 16'h0031, '0, '0, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      for (int i = 0; i < NUM_TRK; i++) begin
        if (p == 1) addrs[i] = (i % 2) ? {ADDR_W{1'b1}} : '0;
        else if (i > 0 && $urandom_range(0, 3) == 0) addrs[i] = addrs[i-1];
        else addrs[i] = ADDR_W'({$urandom, $urandom});
      end
      configure(COUNT_W'(count_tab[p]), addrs);
      for (int k = 0; k < 4; k++) op_weight[k] = mix[p][k];
      tx_idle = (p != 2);
      rx_idle = (p != 2);
      // hold results off so the block backs up and stalls requests
      if (p == 3) hold_results = 1'b1;
      done = 0;
      while (done < PHASE_REQS) begin
        send_random(useful);
        if (useful) done++;
      end
    end

    drain();
    repeat (80) @(posedge clk);
    $display("Run covered %0d requests over %0d register settings, %0d results checked",
             sb.accepted, config_count, sb.checked);
    $display("Pushed high %0d, low %0d, full %0d, terminated %0d, selected %0d, empty %0d, miss %0d",
             sb.action_hits[ACT_HIGH], sb.action_hits[ACT_LOW], sb.action_hits[ACT_FULL],
             sb.action_hits[ACT_TERM], sb.action_hits[ACT_SEL], sb.action_hits[ACT_EMPTY],
             sb.action_hits[ACT_MISS]);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/tcss_pkg.sv
src/tcss_stack.sv
src/two_class_state_scheduler.sv
src/tcss_checker.sv
test/two_class_state_scheduler_tb.sv
